/* design/oidset_pkg.sv */
// Shared types and constants for the ordered identifier set.
package oidset_pkg;

	localparam int DefTableDepth = 16;
	localparam int DefIdWidth    = 16;
	localparam int CapWidth      = 5;
	localparam int StatusWidth   = 3;
	localparam int CountWidth    = 8;
	localparam int FieldIdWidth  = 16;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LIST   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_ADDED    = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_ENTRY    = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	typedef struct packed {
		status_t                 status;
		logic [FieldIdWidth-1:0] listed_id;
		logic                    last;
	} result_t;

endpackage

/* design/oidset_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module oidset_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/oidset_ctrl.sv */
// Sequencer that scans, compacts and lists the identifier memory.
module oidset_ctrl
	import oidset_pkg::*;
#(
	parameter int TableDepth = DefTableDepth,
	parameter int IdWidth    = DefIdWidth
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  op_t                      in_op,
	input  logic [IdWidth-1:0]       in_id,
	input  logic [CountWidth-1:0]    in_count,
	input  logic [CapWidth-1:0]      cap_limit,
	output logic                     out_valid,
	input  logic                     out_ready,
	output result_t                  out_res,
	output logic                     mem_we,
	output logic [$clog2(TableDepth+1)-1:0] mem_waddr_w,
	output logic [IdWidth-1:0]       mem_wdata,
	output logic [$clog2(TableDepth+1)-1:0] mem_raddr_w,
	input  logic [IdWidth-1:0]       mem_rdata
);

	localparam int CW = $clog2(TableDepth + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHIFT, S_LIST, S_OUT
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [IdWidth-1:0] id_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    n_q;
	logic             rd_pend_q;
	logic             out_valid_q;
	result_t          res_q;
	logic [CW-1:0]    cap_eff;
	logic [CW-1:0]    want_clip;

	always_comb begin
		if (32'(cap_limit) < TableDepth) begin
			cap_eff = CW'(cap_limit);
		end else begin
			cap_eff = CW'(TableDepth);
		end
		if (32'(in_count) < 32'(count_q)) begin
			want_clip = CW'(in_count);
		end else begin
			want_clip = count_q;
		end
	end

	assign in_ready    = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid   = out_valid_q;
	assign out_res     = res_q;
	assign mem_raddr_w = idx_q;
	assign mem_waddr_w = (state_q == S_SHIFT) ? idx_q - CW'(2) : count_q;
	assign mem_wdata   = (state_q == S_SHIFT) ? mem_rdata : id_q;
	assign mem_we      = ((state_q == S_SCAN) && rd_pend_q && op_q == OP_ADD
				&& idx_q == count_q && mem_rdata != id_q)
			|| ((state_q == S_SCAN) && !rd_pend_q && op_q == OP_ADD
				&& count_q == '0)
			|| ((state_q == S_SHIFT) && rd_pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= OP_NONE;
			id_q        <= '0;
			res_q       <= '0;
			n_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q      <= in_op;
						id_q      <= in_id;
						idx_q     <= '0;
						rd_pend_q <= 1'b0;
						n_q       <= want_clip;
						case (in_op)
							OP_ADD: begin
								if (count_q >= cap_eff) begin
									res_q       <= '{ST_FULL, '0, 1'b1};
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_REMOVE: state_q <= S_SCAN;
							OP_LIST: begin
								if (want_clip == '0) begin
									res_q       <= '{ST_EMPTY, '0, 1'b1};
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_LIST;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_pend_q && mem_rdata == id_q) begin
						rd_pend_q   <= 1'b0;
						out_valid_q <= (op_q == OP_ADD);
						if (op_q == OP_ADD) begin
							res_q   <= '{ST_PRESENT, '0, 1'b1};
							state_q <= S_OUT;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (idx_q == count_q && (rd_pend_q || count_q == '0)
							&& !(rd_pend_q && idx_q != count_q)) begin
						rd_pend_q   <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
						if (op_q == OP_ADD) begin
							res_q   <= '{ST_ADDED, '0, 1'b1};
							count_q <= count_q + CW'(1);
						end else begin
							res_q <= '{ST_NOTFOUND, '0, 1'b1};
						end
					end else begin
						rd_pend_q <= 1'b1;
						idx_q     <= idx_q + CW'(1);
					end
				end
				S_SHIFT: begin
					if (idx_q >= count_q) begin
						count_q     <= count_q - CW'(1);
						res_q       <= '{ST_REMOVED, '0, 1'b1};
						out_valid_q <= 1'b1;
						rd_pend_q   <= 1'b0;
						state_q     <= S_OUT;
					end else begin
						rd_pend_q <= 1'b1;
						idx_q     <= idx_q + CW'(1);
					end
				end
				S_LIST: begin
					if (rd_pend_q && (!out_valid_q || out_ready)) begin
						res_q       <= '{ST_ENTRY, FieldIdWidth'(mem_rdata), idx_q == n_q};
						out_valid_q <= 1'b1;
						rd_pend_q   <= 1'b0;
						if (idx_q == n_q) begin
							state_q <= S_OUT;
						end
					end else if (!rd_pend_q && (!out_valid_q || out_ready)) begin
						out_valid_q <= 1'b0;
						rd_pend_q   <= 1'b1;
						idx_q       <= idx_q + CW'(1);
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= TableDepth)
		else $error("entry count exceeds table depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid_q)
		else $error("accepted while a result is pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(res_q))
		else $error("result changed while stalled");

endmodule

/* design/ordered_id_set_with_capacity.sv */
// Top level of the ordered identifier set with configurable capacity.
// Add and remove scan the memory one entry per cycle.
// Remove then compacts the later entries, one per cycle, before its result.
// List reads each entry via its read port, then outputs it; a held result stalls it.
// Results pass a single output register; a new item is taken after it drains.
// Asynchronous reset empties the set and sets the capacity to 16.
module ordered_id_set_with_capacity
	import oidset_pkg::*;
#(
	parameter int TableDepth = DefTableDepth,
	parameter int IdWidth    = DefIdWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // op[1:0], member_id[17:2], list_count[25:18]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // status[2:0], listed_id[18:3]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	localparam int CW = $clog2(TableDepth + 1);
	localparam int AW = $clog2(TableDepth);

	logic [CapWidth-1:0] cap_q;
	logic                mem_we;
	logic [CW-1:0]       mem_waddr;
	logic [CW-1:0]       mem_raddr;
	logic [IdWidth-1:0]  mem_wdata;
	logic [IdWidth-1:0]  mem_rdata;
	result_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapWidth'(16);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	oidset_ctrl #(.TableDepth(TableDepth), .IdWidth(IdWidth)) u_ctrl (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (op_t'(s_axis_tdata[1:0])),
		.in_id    (IdWidth'(s_axis_tdata[17:2])),
		.in_count (s_axis_tdata[25:18]),
		.cap_limit(cap_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res),
		.mem_we,
		.mem_waddr_w(mem_waddr),
		.mem_wdata,
		.mem_raddr_w(mem_raddr),
		.mem_rdata
	);

	oidset_ram #(.Width(IdWidth), .Depth(TableDepth)) u_ram (
		.clk,
		.we   (mem_we),
		.waddr(mem_waddr[AW-1:0]),
		.wdata(mem_wdata),
		.raddr(mem_raddr[AW-1:0]),
		.rdata(mem_rdata)
	);

	assign m_axis_tdata = {5'd0, res.listed_id, res.status};
	assign m_axis_tlast = res.last;

endmodule
